[hw/rtl/tpps_pkg.sv]
package tpps_pkg;

	localparam int DURATION_BITS = 8;
	localparam int COUNT_BITS    = DURATION_BITS + 2;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [3:0] LED_WAIT = 4'b0010;
	localparam logic [3:0] LED_DONE = 4'b1111;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_AUTO_MODE      = 3'd0,
		REG_FIRST_PATTERN  = 3'd1,
		REG_SECOND_PATTERN = 3'd2,
		REG_THIRD_PATTERN  = 3'd3,
		REG_MANUAL_PUMPS   = 3'd4,
		REG_FIRST_SECONDS  = 3'd5,
		REG_SECOND_SECONDS = 3'd6,
		REG_THIRD_SECONDS  = 3'd7
	} tpps_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_FIRST  = 3'd1,
		PH_SECOND = 3'd2,
		PH_WAIT   = 3'd3,
		PH_THIRD  = 3'd4,
		PH_DONE   = 3'd5,
		PH_MANUAL = 3'd6
	} tpps_phase_t;

	typedef enum logic [1:0] {
		PAT_INJECT  = 2'd0,
		PAT_BOTH    = 2'd1,
		PAT_OFF     = 2'd2,
		PAT_EXHAUST = 2'd3
	} tpps_pat_t;

	typedef struct packed {
		logic switch_level;
		logic second_tick;
	} tpps_in_t;

	typedef struct packed {
		logic [3:0] led_pattern;
		logic       inject_pump;
		logic       exhaust_pump;
		logic [2:0] phase;
		logic       sample_strobe;
		logic       report_strobe;
		logic       end_of_collection;
	} tpps_out_t;

	typedef struct packed {
		logic                     auto_mode;
		logic [1:0]               first_pattern;
		logic [1:0]               second_pattern;
		logic [1:0]               third_pattern;
		logic [1:0]               manual_pumps;
		logic [DURATION_BITS-1:0] first_seconds;
		logic [DURATION_BITS-1:0] second_seconds;
		logic [DURATION_BITS-1:0] third_seconds;
	} tpps_cfg_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] second_count;
		logic                  waiting;
		logic                  press_seen;
		logic                  wait_finished;
		logic [3:0]            led_hold;
		logic [1:0]            pump_hold;
	} tpps_state_t;

	function automatic logic [3:0] pat_led(input logic [1:0] p);
		logic [3:0] r;
		case (tpps_pat_t'(p))
			PAT_INJECT:  r = 4'b0100;
			PAT_BOTH:    r = 4'b0101;
			PAT_OFF:     r = 4'b1000;
			PAT_EXHAUST: r = 4'b0001;
			default:     r = 4'b1000;
		endcase
		return r;
	endfunction

	// Bit 1 drives the inject pump, bit 0 the exhaust pump.
	function automatic logic [1:0] pat_pump(input logic [1:0] p);
		logic [1:0] r;
		case (tpps_pat_t'(p))
			PAT_INJECT:  r = 2'b10;
			PAT_BOTH:    r = 2'b11;
			PAT_OFF:     r = 2'b00;
			PAT_EXHAUST: r = 2'b01;
			default:     r = 2'b00;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/tpps_cfg.sv]
module tpps_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [tpps_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  logic [tpps_pkg::DURATION_BITS-1:0]  wr_data,
	output tpps_pkg::tpps_cfg_t                 cfg
);
	import tpps_pkg::*;

	tpps_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_mode      <= 1'b1;
			cfg_q.first_pattern  <= PAT_OFF;
			cfg_q.second_pattern <= PAT_INJECT;
			cfg_q.third_pattern  <= PAT_BOTH;
			cfg_q.manual_pumps   <= 2'b00;
			cfg_q.first_seconds  <= DURATION_BITS'(30);
			cfg_q.second_seconds <= DURATION_BITS'(30);
			cfg_q.third_seconds  <= DURATION_BITS'(60);
		end else if (wr_en) begin
			case (wr_index)
				REG_AUTO_MODE:      cfg_q.auto_mode      <= wr_data[0];
				REG_FIRST_PATTERN:  cfg_q.first_pattern  <= wr_data[1:0];
				REG_SECOND_PATTERN: cfg_q.second_pattern <= wr_data[1:0];
				REG_THIRD_PATTERN:  cfg_q.third_pattern  <= wr_data[1:0];
				REG_MANUAL_PUMPS:   cfg_q.manual_pumps   <= wr_data[1:0];
				REG_FIRST_SECONDS:  cfg_q.first_seconds  <= wr_data;
				REG_SECOND_SECONDS: cfg_q.second_seconds <= wr_data;
				REG_THIRD_SECONDS:  cfg_q.third_seconds  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/tpps_step.sv]
module tpps_step (
	input  tpps_pkg::tpps_cfg_t   cfg,
	input  tpps_pkg::tpps_state_t st,
	input  tpps_pkg::tpps_in_t    din,
	output tpps_pkg::tpps_state_t st_nxt,
	output tpps_pkg::tpps_out_t   dout
);
	import tpps_pkg::*;

	logic [COUNT_BITS-1:0] end1, end2, total;
	logic [COUNT_BITS-1:0] cnt_inc, cnt_use;
	logic                  in_third, past_total;
	logic                  sample, report, eoc;
	tpps_phase_t           phase;

	assign end1  = COUNT_BITS'(cfg.first_seconds);
	assign end2  = end1 + COUNT_BITS'(cfg.second_seconds);
	assign total = end2 + COUNT_BITS'(cfg.third_seconds);

	assign cnt_inc = (st.second_count == COUNT_MAX) ? st.second_count
	                                                : st.second_count + 1'b1;

	// The third-phase decision looks at the held count when leaving the wait
	// and at the freshly ticked count otherwise.
	assign cnt_use    = st.waiting ? st.second_count : cnt_inc;
	assign in_third   = (cnt_use > end2) && (cnt_use <= total);
	assign past_total = cnt_use > total;

	always_comb begin
		st_nxt = st;
		sample = 1'b0;
		report = 1'b0;
		eoc    = 1'b0;

		if (!cfg.auto_mode) begin
			st_nxt.pump_hold = cfg.manual_pumps;
			st_nxt.led_hold  = {1'b1, cfg.manual_pumps[1], cfg.manual_pumps[0], 1'b1};
			sample           = 1'b1;
			report           = din.second_tick;
		end else if (st.waiting) begin
			st_nxt.led_hold  = LED_WAIT;
			st_nxt.pump_hold = 2'b00;
			if (!din.switch_level) begin
				st_nxt.press_seen = 1'b1;
			end else if (st.press_seen) begin
				st_nxt.waiting       = 1'b0;
				st_nxt.wait_finished = 1'b1;
				if (in_third) begin
					st_nxt.led_hold  = pat_led(cfg.third_pattern);
					st_nxt.pump_hold = pat_pump(cfg.third_pattern);
					report           = 1'b1;
				end else if (past_total) begin
					st_nxt.led_hold  = LED_DONE;
					st_nxt.pump_hold = 2'b00;
				end
			end
		end else if (!din.switch_level) begin
			st_nxt = '0;
		end else begin
			sample = st.second_count <= total;
			if (din.second_tick) begin
				st_nxt.second_count = cnt_inc;
				if (cnt_inc <= end1) begin
					st_nxt.led_hold  = pat_led(cfg.first_pattern);
					st_nxt.pump_hold = pat_pump(cfg.first_pattern);
					report           = 1'b1;
				end else if (cnt_inc <= end2) begin
					st_nxt.led_hold  = pat_led(cfg.second_pattern);
					st_nxt.pump_hold = pat_pump(cfg.second_pattern);
					report           = 1'b1;
				end else if (!st.wait_finished) begin
					st_nxt.waiting   = 1'b1;
					st_nxt.led_hold  = LED_WAIT;
					st_nxt.pump_hold = 2'b00;
					eoc              = 1'b1;
				end else if (in_third) begin
					st_nxt.led_hold  = pat_led(cfg.third_pattern);
					st_nxt.pump_hold = pat_pump(cfg.third_pattern);
					report           = 1'b1;
				end else if (past_total) begin
					st_nxt.led_hold  = LED_DONE;
					st_nxt.pump_hold = 2'b00;
				end
			end
		end
	end

	// The phase is read from the state after this word has been applied.
	always_comb begin
		if (!cfg.auto_mode) begin
			phase = PH_MANUAL;
		end else if (st_nxt.waiting) begin
			phase = PH_WAIT;
		end else if (st_nxt.second_count == '0) begin
			phase = PH_IDLE;
		end else if (st_nxt.second_count <= end1) begin
			phase = PH_FIRST;
		end else if (st_nxt.second_count <= end2 || !st_nxt.wait_finished) begin
			phase = PH_SECOND;
		end else if (st_nxt.second_count <= total) begin
			phase = PH_THIRD;
		end else begin
			phase = PH_DONE;
		end
	end

	always_comb begin
		dout.led_pattern       = st_nxt.led_hold;
		dout.inject_pump       = st_nxt.pump_hold[1];
		dout.exhaust_pump      = st_nxt.pump_hold[0];
		dout.phase             = phase;
		dout.sample_strobe     = sample;
		dout.report_strobe     = report;
		dout.end_of_collection = eoc;
	end

endmodule

[hw/rtl/timed_pump_phase_sequencer_top.sv]
// Pump phase sequencer: every accepted input word (switch level, second tick)
// yields exactly one result word in the cycle after it, and a new word is taken in
// every cycle as long as the result register is empty or is being drained in
// the same cycle; the whole state update is one pass of logic from the run
// state register to the result register. Configuration writes are taken at
// once and should only be issued while no result is pending.
module timed_pump_phase_sequencer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  tpps_pkg::tpps_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tpps_pkg::tpps_out_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tpps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [tpps_pkg::DURATION_BITS-1:0]  cfg_data
);
	import tpps_pkg::*;

	tpps_cfg_t   cfg;
	tpps_state_t state_q, state_nxt;
	tpps_out_t   result, out_data_q;
	logic        out_valid_q;
	logic        in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	tpps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tpps_step u_step (
		.cfg    (cfg),
		.st     (state_q),
		.din    (in_data),
		.st_nxt (state_nxt),
		.dout   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				state_q <= state_nxt;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
